/* design/apsp_pkg.sv */
package apsp_pkg;

   localparam int DIST_W  = 26;
   localparam int ENTRY_W = DIST_W + 1;

   localparam logic [ENTRY_W-1:0] UNREACH_ENTRY = {1'b1, {DIST_W{1'b0}}};
   localparam logic [DIST_W-1:0]  DIST_MAX      = {DIST_W{1'b1}};

   typedef enum logic [1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_LOAD    = 2'd1,
      ACT_COMPUTE = 2'd2,
      ACT_READ    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_ROW,
      ST_IK,
      ST_SWEEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

/* design/apsp_ram.sv */
module apsp_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/apsp_cell.sv */
module apsp_cell import apsp_pkg::*; (
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic               wrap,
   input  logic [ENTRY_W-1:0] nbr_val,
   input  logic [ENTRY_W-1:0] head_val,
   input  logic [ENTRY_W-1:0] load_val,
   output logic [ENTRY_W-1:0] val
);

   logic [ENTRY_W-1:0] val_ff;
   logic [ENTRY_W-1:0] val_in;

   // the last live cell closes the ring, or takes fresh row data while loading
   always_comb begin
      val_in = val_ff;
      if (ctrl.shift) begin
         if (wrap) begin
            val_in = ctrl.load ? load_val : head_val;
         end else begin
            val_in = nbr_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule

/* design/all_pairs_shortest_path.sv */
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    action, src_vertex, dst_vertex, edge_weight
// rsp      out        rsp_valid/stall    distance, unreachable
// csr      in         csr_valid/ready    num_vertices
//
// Load edge and out-of-range reads answer on acceptance; an in-range read answers after
// one registered read of the matrix RAM, whether the entry is reachable or not.
// Clear sweeps the RAM, one entry a cycle, over 2^(2*clog2(MAX_VERTICES)) entries,
// which is MAX_VERTICES^2 for a power of two.
// Compute, for n vertices in use: per k, row k is copied into the ring of cells, then
// for each row i the RAM reads d[i][k], then d[i][j] for every j.
// The result of every item is posted on acceptance or at the end of its read; a busy
// sequencer or a stalled result register holds req_stall high.
// Reset is synchronous; the matrix is undefined until cleared or loaded.
module all_pairs_shortest_path import apsp_pkg::*; #(
   parameter int MAX_VERTICES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [5:0]  req_src_vertex,
   input  logic [5:0]  req_dst_vertex,
   input  logic [19:0] req_edge_weight,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [25:0] rsp_distance,
   output logic        rsp_unreachable,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_num_vertices
);

   localparam int IW    = $clog2(MAX_VERTICES);
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int XW    = (CW > 7) ? CW : 7;
   localparam int AW    = 2 * IW;
   localparam int DEPTH = 1 << AW;

   // configuration
   logic [6:0] num_vertices_ff;
   logic [XW-1:0] n_eff;

   // sequencer
   state_type state_ff, state_in;
   logic [IW-1:0] k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [IW-1:0] n_m1_ff, n_m1_in;
   logic [AW-1:0] clr_ff, clr_in;

   // read pipeline tags
   logic p_load_ff, p_load_in, p_ik_ff, p_ik_in, p_ij_ff, p_ij_in;
   logic [AW-1:0] pa_ff;
   logic [ENTRY_W-1:0] ik_ff;

   // result register
   logic rsp_valid_ff, rsp_load;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic rsp_unr_ff, rsp_unr_in;

   // RAM
   logic ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   // ring of cells holding row k
   logic [ENTRY_W-1:0] cell_val [MAX_VERTICES];
   cell_ctrl_type cell_ctrl;

   logic req_accept;
   logic src_ok, dst_ok;
   logic [IW-1:0] src_idx, dst_idx;
   logic [ENTRY_W-1:0] kj;
   logic [DIST_W:0] sum_raw;
   logic [DIST_W-1:0] sum_sat;
   logic relax_wr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vertices_ff <= 7'd64;
      end else if (csr_valid && csr_ready) begin
         num_vertices_ff <= csr_num_vertices;
      end
   end

   // effective count is capped at the matrix size
   assign n_eff = (XW'(num_vertices_ff) < XW'(MAX_VERTICES)) ?
                  XW'(num_vertices_ff) : XW'(MAX_VERTICES);

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign src_ok  = XW'(req_src_vertex) < n_eff;
   assign dst_ok  = XW'(req_dst_vertex) < n_eff;
   assign src_idx = IW'(req_src_vertex);
   assign dst_idx = IW'(req_dst_vertex);

   // relaxation datapath: cell 0 holds d[k][j] for the entry now returning
   assign kj      = cell_val[0];
   assign sum_raw = {1'b0, ik_ff[DIST_W-1:0]} + {1'b0, kj[DIST_W-1:0]};
   assign sum_sat = sum_raw[DIST_W] ? DIST_MAX : sum_raw[DIST_W-1:0];
   assign relax_wr = p_ij_ff && !ik_ff[DIST_W] && !kj[DIST_W] &&
                     (ram_rdata[DIST_W] || (sum_sat < ram_rdata[DIST_W-1:0]));

   // next state and loop counters
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      n_m1_in  = n_m1_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (action_type'(req_action))
                  ACT_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  ACT_COMPUTE: begin
                     k_in    = '0;
                     j_in    = '0;
                     n_m1_in = IW'(n_eff - XW'(1));
                     if (n_eff != '0) begin
                        state_in = ST_ROW;
                     end
                  end
                  ACT_READ: begin
                     if (src_ok && dst_ok) begin
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_ROW: begin
            if (j_ff == n_m1_ff) begin
               j_in     = '0;
               i_in     = '0;
               state_in = ST_IK;
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         ST_IK: begin
            j_in     = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (j_ff == n_m1_ff) begin
               j_in = '0;
               if (i_ff == n_m1_ff) begin
                  if (k_ff == n_m1_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     k_in     = k_ff + IW'(1);
                     state_in = ST_ROW;
                  end
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_IK;
               end
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // RAM port, pipeline tags and result
   always_comb begin
      ram_we      = 1'b0;
      ram_waddr   = pa_ff;
      ram_wdata   = {1'b0, sum_sat};
      ram_raddr   = {i_ff, j_ff};
      p_load_in   = 1'b0;
      p_ik_in     = 1'b0;
      p_ij_in     = 1'b0;
      rsp_load    = 1'b0;
      rsp_dist_in = '0;
      rsp_unr_in  = 1'b0;
      // drain the last relaxation of a row whatever state follows
      if (relax_wr) begin
         ram_we = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = {src_idx, dst_idx};
            if (req_accept) begin
               case (action_type'(req_action))
                  ACT_LOAD: begin
                     rsp_load  = 1'b1;
                     ram_we    = src_ok && dst_ok && (req_src_vertex != req_dst_vertex);
                     ram_waddr = {src_idx, dst_idx};
                     ram_wdata = ENTRY_W'(req_edge_weight);
                  end
                  ACT_READ: begin
                     // out of range answers at once; in range waits for the RAM
                     if (!(src_ok && dst_ok)) begin
                        rsp_load   = 1'b1;
                        rsp_unr_in = 1'b1;
                     end
                  end
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = (clr_ff[AW-1:IW] == clr_ff[IW-1:0]) ? '0 : UNREACH_ENTRY;
         end
         ST_READ: begin
            rsp_load   = 1'b1;
            rsp_unr_in = ram_rdata[DIST_W];
            rsp_dist_in = ram_rdata[DIST_W] ? '0 : ram_rdata[DIST_W-1:0];
         end
         ST_ROW: begin
            ram_raddr = {k_ff, j_ff};
            p_load_in = 1'b1;
         end
         ST_IK: begin
            ram_raddr = {i_ff, k_ff};
            p_ik_in   = 1'b1;
         end
         ST_SWEEP: begin
            ram_raddr = {i_ff, j_ff};
            p_ij_in   = 1'b1;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p_load_ff    <= 1'b0;
         p_ik_ff      <= 1'b0;
         p_ij_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         p_load_ff <= p_load_in;
         p_ik_ff   <= p_ik_in;
         p_ij_ff   <= p_ij_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      n_m1_ff <= n_m1_in;
      clr_ff  <= clr_in;
      pa_ff   <= ram_raddr;
      if (p_ik_ff) begin
         ik_ff <= ram_rdata;
      end
      if (rsp_load) begin
         rsp_dist_ff <= rsp_dist_in;
         rsp_unr_ff  <= rsp_unr_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_unreachable = rsp_unr_ff;

   apsp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // advance the ring on row data coming in, or once per relaxed entry
   assign cell_ctrl.shift = p_load_ff || p_ij_ff;
   assign cell_ctrl.load  = p_load_ff;

   for (genvar c = 0; c < MAX_VERTICES; c++) begin : g_cell
      apsp_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .wrap     (n_m1_ff == IW'(c)),
         .nbr_val  (cell_val[(c + 1) % MAX_VERTICES]),
         .head_val (cell_val[0]),
         .load_val (ram_rdata),
         .val      (cell_val[c])
      );
   end

   a_tags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(p_load_ff && p_ij_ff))
      else $error("row load and relaxation overlap");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && rsp_valid_ff && rsp_stall))
      else $error("item accepted over a held result");

   a_read_path: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_action == ACT_READ) && src_ok && dst_ok) |=>
      (state_ff == ST_READ))
      else $error("in-range read did not reach the RAM wait state");

   a_write_only_relax: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && ram_we) |-> relax_wr)
      else $error("unexpected RAM write during sweep");

endmodule

/* verif/apsp_checker.sv */
`timescale 1ns / 100ps

module apsp_checker import apsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [5:0]  req_src_vertex,
   input  logic [5:0]  req_dst_vertex,
   input  logic [19:0] req_edge_weight,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [25:0] rsp_distance,
   input  logic        rsp_unreachable,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [6:0]  csr_num_vertices,
   output int          fail_count,
   output int          pending
);

   localparam int MAXV = 64;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              unreachable;
   } path_result_type;

   logic [ENTRY_W-1:0] dist_mat [0:MAXV*MAXV-1];
   logic [6:0]         vertex_cfg;
   path_result_type    path_q[$];

   function automatic int active_vertices();
      return (vertex_cfg < MAXV) ? int'(vertex_cfg) : MAXV;
   endfunction

   // Floyd-Warshall relaxation in k, i, j order on the shadow matrix
   function automatic void relax_paths(input int nv);
      logic [ENTRY_W-1:0] ik, kj, ij;
      logic [DIST_W:0]    sum;
      for (int k = 0; k < nv; k++)
         for (int i = 0; i < nv; i++) begin
            if (dist_mat[i*MAXV+k][DIST_W]) continue;
            for (int j = 0; j < nv; j++) begin
               kj = dist_mat[k*MAXV+j];
               ij = dist_mat[i*MAXV+j];
               if (kj[DIST_W]) continue;
               ik = dist_mat[i*MAXV+k];
               sum = {1'b0, ik[DIST_W-1:0]} + {1'b0, kj[DIST_W-1:0]};
               if (sum[DIST_W]) sum = {1'b0, DIST_MAX};
               if (ij[DIST_W] || sum[DIST_W-1:0] < ij[DIST_W-1:0])
                  dist_mat[i*MAXV+j] = {1'b0, sum[DIST_W-1:0]};
            end
         end
   endfunction

   function automatic path_result_type shortest_path_result();
      path_result_type r;
      int nv;
      nv = active_vertices();
      r = '0;
      case (action_type'(req_action))
         ACT_CLEAR: begin
            for (int i = 0; i < MAXV; i++)
               for (int j = 0; j < MAXV; j++)
                  dist_mat[i*MAXV+j] = (i == j) ? '0 : UNREACH_ENTRY;
         end
         ACT_LOAD: begin
            if (req_src_vertex < nv && req_dst_vertex < nv && req_src_vertex != req_dst_vertex)
               dist_mat[req_src_vertex*MAXV+req_dst_vertex] = {7'd0, req_edge_weight};
         end
         ACT_COMPUTE: relax_paths(nv);
         default: begin
            if (req_src_vertex < nv && req_dst_vertex < nv) begin
               if (dist_mat[req_src_vertex*MAXV+req_dst_vertex][DIST_W])
                  r.unreachable = 1'b1;
               else
                  r.distance = dist_mat[req_src_vertex*MAXV+req_dst_vertex][DIST_W-1:0];
            end else begin
               r.unreachable = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      path_result_type want;
      if (reset) begin
         path_q.delete();
         vertex_cfg = 7'd64;
         fail_count = 0;
         for (int e = 0; e < MAXV*MAXV; e++) dist_mat[e] = '0;
      end else begin
         if (csr_valid && csr_ready) vertex_cfg = csr_num_vertices;
         if (req_valid && !req_stall) path_q.push_back(shortest_path_result());
         if (rsp_valid && !rsp_stall) begin
            if (path_q.size() == 0) begin
               $error("unexpected transfer on rsp: distance %0d unreachable %0d",
                      rsp_distance, rsp_unreachable);
               fail_count++;
            end else begin
               want = path_q.pop_front();
               if (rsp_distance !== want.distance) begin
                  $error("rsp_distance mismatch: expected %0d, got %0d",
                         want.distance, rsp_distance);
                  fail_count++;
               end
               if (rsp_unreachable !== want.unreachable) begin
                  $error("rsp_unreachable mismatch: expected %0d, got %0d",
                         want.unreachable, rsp_unreachable);
                  fail_count++;
               end
            end
         end
      end
      pending = path_q.size();
   end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb import apsp_pkg::*; ();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = ACT_CLEAR;
   logic [5:0]  req_src_vertex = '0;
   logic [5:0]  req_dst_vertex = '0;
   logic [19:0] req_edge_weight = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [25:0] rsp_distance;
   logic        rsp_unreachable;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_num_vertices = 7'd64;

   int fail_count;
   int pending;

   // knobs for the idling phases
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   // long receiver hold-off, requested by the stimulus, counted by the receiver
   logic hold_request = 1'b0;
   int   hold_left = 0;
   // cycles the block may still be busy after the last result has come back
   int   busy_tail = 4;
   int   vertex_count = 64;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   all_pairs_shortest_path DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_action, .req_src_vertex, .req_dst_vertex,
      .req_edge_weight,
      .rsp_valid, .rsp_stall, .rsp_distance, .rsp_unreachable,
      .csr_valid, .csr_ready, .csr_num_vertices
   );

   apsp_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_action, .req_src_vertex, .req_dst_vertex,
      .req_edge_weight,
      .rsp_valid, .rsp_stall, .rsp_distance, .rsp_unreachable,
      .csr_valid, .csr_ready, .csr_num_vertices,
      .fail_count, .pending
   );

   // Receiver: random stalls, or a long hold-off once requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_request) begin
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Offer one transfer on req and hold it until accepted; keep valid high
   // between back-to-back transfers.
   task automatic send_op(input action_type act, input int src, input int dst,
                          input int weight);
      int nv;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_src_vertex  <= src[5:0];
      req_dst_vertex  <= dst[5:0];
      req_edge_weight <= weight[19:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      nv = (vertex_count < 64) ? vertex_count : 64;
      case (act)
         ACT_CLEAR:   busy_tail = 4200;
         ACT_COMPUTE: busy_tail = nv * nv * (nv + 2) + 20;
         default:     busy_tail = 4;
      endcase
   endtask

   // Drop valid, drain every result, let the sequencer finish
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (busy_tail) @(posedge clock);
      busy_tail = 4;
   endtask

   // Write the vertex count while the block is idle
   task automatic set_vertices(input int nv);
      drain();
      csr_valid        <= 1'b1;
      csr_num_vertices <= nv[6:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      vertex_count = nv;
   endtask

   function automatic int pick_weight();
      case ($urandom_range(9))
         0:       return 20'hFFFFF;
         1:       return 0;
         2, 3:    return $urandom_range(20'hFFFFF);
         default: return $urandom_range(1, 200);
      endcase
   endfunction

   // Vertex index: mostly in range, sometimes beyond the count in use
   function automatic int pick_vertex(input int nv);
      if (nv > 0 && $urandom_range(9) != 0) return $urandom_range(nv - 1);
      return $urandom_range(63);
   endfunction

   initial begin
      int nv;
      int loads;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: full size, extremes of every field
      send_op(ACT_CLEAR, 0, 0, 0);
      send_op(ACT_READ, 63, 63, 0);
      send_op(ACT_READ, 0, 63, 0);
      send_op(ACT_LOAD, 0, 1, 7);
      send_op(ACT_LOAD, 0, 1, 3);          // overwrite of the same edge
      send_op(ACT_LOAD, 1, 2, 20'hFFFFF);
      send_op(ACT_LOAD, 2, 63, 20'hFFFFF);
      send_op(ACT_LOAD, 63, 0, 0);
      send_op(ACT_LOAD, 5, 5, 99);         // self edge stays 0
      send_op(ACT_READ, 0, 1, 0);
      send_op(ACT_READ, 5, 5, 0);
      send_op(ACT_COMPUTE, 0, 0, 0);
      send_op(ACT_READ, 0, 63, 0);
      send_op(ACT_READ, 63, 2, 0);
      send_op(ACT_READ, 3, 4, 0);

      // Zero vertices: every vertex out of range, compute is a no-op
      set_vertices(0);
      send_op(ACT_LOAD, 0, 1, 1);
      send_op(ACT_COMPUTE, 0, 0, 0);
      send_op(ACT_READ, 0, 1, 0);

      // Count above the matrix size clamps to full size
      set_vertices(127);
      send_op(ACT_READ, 63, 0, 0);

      // Single vertex
      set_vertices(1);
      send_op(ACT_CLEAR, 0, 0, 0);
      send_op(ACT_LOAD, 0, 1, 5);
      send_op(ACT_COMPUTE, 0, 0, 0);
      send_op(ACT_READ, 0, 0, 0);
      send_op(ACT_READ, 1, 0, 0);

      // Random graph problems: configure, clear, load, compute, read
      for (int seq = 0; seq < 40; seq++) begin
         case ((seq / 5) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         case ($urandom_range(9))
            0:       nv = $urandom_range(0, 1);
            1:       nv = $urandom_range(64, 127);
            2:       nv = $urandom_range(13, 20);
            default: nv = $urandom_range(2, 10);
         endcase
         if (nv >= 64 && seq % 3 != 0) nv = 8;
         set_vertices(nv);
         send_op(ACT_CLEAR, 0, 0, 0);

         // In one sequence, hold the receiver off while loads keep coming; the block fills up
         loads = $urandom_range(6, 16);
         for (int n = 0; n < loads; n++) begin
            if (seq == 3 && n == 1) begin
               req_valid    <= 1'b0;
               hold_request <= 1'b1;
               @(posedge clock);
               hold_request <= 1'b0;
            end
            if ($urandom_range(7) == 0)
               send_op(ACT_READ, pick_vertex(nv), pick_vertex(nv), $urandom);
            else
               send_op(ACT_LOAD, pick_vertex(nv), pick_vertex(nv), pick_weight());
         end

         // Pause the sender until every expected result has come back
         if (seq == 7) drain();

         send_op(ACT_COMPUTE, $urandom, $urandom, $urandom);
         repeat ($urandom_range(10, 18))
            send_op(ACT_READ, pick_vertex(nv), pick_vertex(nv), $urandom);

         // Occasionally extend the graph and relax again
         if ($urandom_range(3) == 0) begin
            repeat (3) send_op(ACT_LOAD, pick_vertex(nv), pick_vertex(nv), pick_weight());
            send_op(ACT_COMPUTE, 0, 0, 0);
            repeat (6) send_op(ACT_READ, pick_vertex(nv), pick_vertex(nv), 0);
         end
      end

      // Bulk reads, loads and occasional computes on a small graph to reach the item count
      set_vertices(6);
      send_op(ACT_CLEAR, 0, 0, 0);
      for (int n = 0; n < 150; n++) begin
         send_idle_pct  = (n < 75) ? 24 : 0;
         recv_stall_pct = (n < 75) ? 24 : 0;
         case ($urandom_range(5))
            0:       send_op(ACT_LOAD, pick_vertex(6), pick_vertex(6), pick_weight());
            1:       if ($urandom_range(7) == 0) send_op(ACT_COMPUTE, 0, 0, 0);
                     else send_op(ACT_READ, pick_vertex(6), pick_vertex(6), 0);
            default: send_op(ACT_READ, pick_vertex(6), pick_vertex(6), $urandom);
         endcase
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #100000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
